FILE: rtl/core/consecutive_grant_throttle_table_unit_assert.svh
// Assertion macros for the consecutive grant throttle table unit.
`ifndef CONSECUTIVE_GRANT_THROTTLE_TABLE_UNIT_ASSERT_SVH
`define CONSECUTIVE_GRANT_THROTTLE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define CGTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cgtt assertion failed");

// Invariant that must hold at every sampled edge out of reset.
`define CGTT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) 1'b1 |-> (prop)) \
    else $error("cgtt invariant failed");

`endif

FILE: rtl/core/cgtt_pkg.sv
// Package: types and constants for the consecutive grant throttle table.
package cgtt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned CNT_W   = 8;

  localparam logic [TICK_W-1:0] TICK_NONE = '1;
  localparam logic [CNT_W-1:0]  RUN_MAX   = '1;

  typedef enum logic [1:0] {
    CMD_QUERY_DL = 2'd0,
    CMD_QUERY_UL = 2'd1,
    CMD_NOTE_DL  = 2'd2,
    CMD_NOTE_UL  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  // Item as it walks down the chain; done marks that a cell has served it.
  typedef struct packed {
    cmd_e              cmd;
    logic [KEY_W-1:0]  key;
    logic [TICK_W-1:0] tick;
    logic [CNT_W-1:0]  limit;
    logic              done;
    logic              throttle;
    status_e           status;
  } pay_t;

endpackage

FILE: rtl/core/cgtt_cell.sv
// One table entry plus the pipeline register that carries an item past it.
module cgtt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           req_vld_i,
  input  cgtt_pkg::pay_t req_i,
  output logic           req_vld_o,
  output cgtt_pkg::pay_t req_o,
  output logic           ent_valid_o
);

  logic                        vld_q;
  cgtt_pkg::pay_t              pay_q, pay_d;

  logic                        ent_valid_q, ent_valid_d;
  logic [cgtt_pkg::KEY_W-1:0]  ent_key_q, ent_key_d;
  logic [cgtt_pkg::TICK_W-1:0] dn_last_q, dn_last_d, up_last_q, up_last_d;
  logic [cgtt_pkg::CNT_W-1:0]  dn_cnt_q, dn_cnt_d, up_cnt_q, up_cnt_d;

  logic                        act, hit, is_up, is_note, consec;
  logic [cgtt_pkg::TICK_W-1:0] last_sel;
  logic [cgtt_pkg::CNT_W-1:0]  cnt_sel, cnt_next;

  always_comb begin
    act      = req_vld_i && !req_i.done;
    hit      = ent_valid_q && (ent_key_q == req_i.key);
    is_up    = (req_i.cmd == cgtt_pkg::CMD_QUERY_UL) || (req_i.cmd == cgtt_pkg::CMD_NOTE_UL);
    is_note  = (req_i.cmd == cgtt_pkg::CMD_NOTE_DL) || (req_i.cmd == cgtt_pkg::CMD_NOTE_UL);
    last_sel = is_up ? up_last_q : dn_last_q;
    cnt_sel  = is_up ? up_cnt_q : dn_cnt_q;
    // last tick equals now - 1 (mod 2^32)
    consec   = (cgtt_pkg::TICK_W'(last_sel + 1'b1) == req_i.tick);
    if (!consec) begin
      cnt_next = cgtt_pkg::CNT_W'(1);
    end else if (cnt_sel == cgtt_pkg::RUN_MAX) begin
      cnt_next = cgtt_pkg::RUN_MAX;
    end else begin
      cnt_next = cgtt_pkg::CNT_W'(cnt_sel + 1'b1);
    end

    pay_d       = req_i;
    ent_valid_d = ent_valid_q;
    ent_key_d   = ent_key_q;
    dn_last_d   = dn_last_q;
    up_last_d   = up_last_q;
    dn_cnt_d    = dn_cnt_q;
    up_cnt_d    = up_cnt_q;

    if (act && hit) begin
      pay_d.done   = 1'b1;
      pay_d.status = cgtt_pkg::ST_HIT;
      if (is_note) begin
        if (is_up) begin
          up_last_d = req_i.tick;
          up_cnt_d  = cnt_next;
        end else begin
          dn_last_d = req_i.tick;
          dn_cnt_d  = cnt_next;
        end
      end else begin
        pay_d.throttle = (req_i.limit != '0) && consec && (cnt_sel >= req_i.limit);
      end
    end else if (act && !ent_valid_q) begin
      // Valid entries form a prefix: the first free cell ends the search.
      pay_d.done = 1'b1;
      if (is_note) begin
        pay_d.status = cgtt_pkg::ST_NEW;
        ent_valid_d  = 1'b1;
        ent_key_d    = req_i.key;
        // Fresh entry: this grant always starts a run of one.
        dn_last_d    = is_up ? cgtt_pkg::TICK_NONE : req_i.tick;
        up_last_d    = is_up ? req_i.tick : cgtt_pkg::TICK_NONE;
        dn_cnt_d     = is_up ? '0 : cgtt_pkg::CNT_W'(1);
        up_cnt_d     = is_up ? cgtt_pkg::CNT_W'(1) : '0;
      end else begin
        pay_d.status = cgtt_pkg::ST_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= 1'b0;
      ent_valid_q <= 1'b0;
    end else if (adv_i) begin
      vld_q       <= req_vld_i;
      ent_valid_q <= ent_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pay_q     <= pay_d;
      ent_key_q <= ent_key_d;
      dn_last_q <= dn_last_d;
      up_last_q <= up_last_d;
      dn_cnt_q  <= dn_cnt_d;
      up_cnt_q  <= up_cnt_d;
    end
  end

  assign req_vld_o   = vld_q;
  assign req_o       = pay_q;
  assign ent_valid_o = ent_valid_q;

endmodule

FILE: rtl/core/consecutive_grant_throttle_table_unit.sv
// An accepted item passes through the pipeline register of every cell in turn.
// Throughput: one item per cycle; the cell chain is a pipeline that holds as a whole
// while the output item is stalled, and each cell serves items in arrival order.
// Reset clears every entry's valid bit and the pipeline valids; the table is empty
// and usable in the first cycle after reset, with no clearing pass.
`include "consecutive_grant_throttle_table_unit_assert.svh"

module consecutive_grant_throttle_table_unit #(
  parameter int unsigned TABLE_ENTRIES = cgtt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  in_command_i,
  input  logic [cgtt_pkg::KEY_W-1:0]  in_user_key_i,
  input  logic [cgtt_pkg::TICK_W-1:0] in_tick_now_i,
  input  logic [cgtt_pkg::CNT_W-1:0]  in_grant_limit_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        out_throttle_o,
  output logic [1:0]                  out_status_o
);

  // Stage k feeds cell k; stage TABLE_ENTRIES is the output register.
  logic                 vld_w [TABLE_ENTRIES+1];
  cgtt_pkg::pay_t       pay_w [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] ent_valid;
  logic                 adv;

  // Whole chain moves when the output slot is empty or being taken.
  assign adv        = !vld_w[TABLE_ENTRIES] || !out_stall_i;
  assign in_stall_o = !adv;

  // New item: not yet served, no throttle, status defaults to "no entry"
  // so that a note that walks off the end reports a full table.
  always_comb begin
    vld_w[0]          = in_valid_i;
    pay_w[0].cmd      = cgtt_pkg::cmd_e'(in_command_i);
    pay_w[0].key      = in_user_key_i;
    pay_w[0].tick     = in_tick_now_i;
    pay_w[0].limit    = in_grant_limit_i;
    pay_w[0].done     = 1'b0;
    pay_w[0].throttle = 1'b0;
    pay_w[0].status   = cgtt_pkg::ST_NONE;
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    cgtt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .req_vld_i   (vld_w[k]),
      .req_i       (pay_w[k]),
      .req_vld_o   (vld_w[k+1]),
      .req_o       (pay_w[k+1]),
      .ent_valid_o (ent_valid[k])
    );
  end

  assign out_valid_o    = vld_w[TABLE_ENTRIES];
  assign out_throttle_o = pay_w[TABLE_ENTRIES].throttle;
  assign out_status_o   = pay_w[TABLE_ENTRIES].status;

  // Checks
  logic [TABLE_ENTRIES:0] fill_plus_one;
  logic                   out_is_note;

  assign fill_plus_one = {1'b0, ent_valid} + 1'b1;
  assign out_is_note   = (pay_w[TABLE_ENTRIES].cmd == cgtt_pkg::CMD_NOTE_DL) ||
                         (pay_w[TABLE_ENTRIES].cmd == cgtt_pkg::CMD_NOTE_UL);

  // Allocated entries always form a prefix of the chain.
  `CGTT_ASSERT_ALWAYS(a_valid_prefix, $onehot(fill_plus_one))
  // A note item never reports throttle.
  `CGTT_ASSERT_IMP(a_note_no_throttle, out_valid_o && out_is_note, !out_throttle_o)
  // Only a note can allocate an entry.
  `CGTT_ASSERT_IMP(a_new_only_note, out_valid_o && (out_status_o == cgtt_pkg::ST_NEW),
                   out_is_note)
  // Throttle is only raised on a hit.
  `CGTT_ASSERT_IMP(a_throttle_on_hit, out_valid_o && out_throttle_o,
                   out_status_o == cgtt_pkg::ST_HIT)

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the consecutive grant throttle table unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cgtt_pkg::*;

  localparam int unsigned TBL_N      = TABLE_ENTRIES_DEF;
  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned N_ITEMS    = 1400;
  localparam int unsigned POOL_N     = 24;
  // Receiver hold-off; well past the 256-deep cell chain so the input stalls.
  localparam int unsigned HOLD_CYC   = 700;
  // Watchdog limit; leave a wide margin over the slowest correct run.
  localparam int unsigned CYC_LIMIT  = 200000;

  // One item offered to the block.
  typedef struct {
    cmd_e              cmd;
    logic [KEY_W-1:0]  key;
    logic [TICK_W-1:0] tick;
    logic [CNT_W-1:0]  limit;
  } grant_req_t;

  // What the block must answer for one item.
  typedef struct {
    logic    throttle;
    status_e status;
  } verdict_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic [1:0]          in_command_i     = 2'b00;
  logic [KEY_W-1:0]    in_user_key_i    = '0;
  logic [TICK_W-1:0]   in_tick_now_i    = '0;
  logic [CNT_W-1:0]    in_grant_limit_i = '0;
  logic                out_stall_i      = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                out_throttle_o;
  logic [1:0]          out_status_o;

  grant_req_t  pend_q[$];     // items still to be offered
  verdict_t    verdict_q[$];  // expected answers, oldest first
  bit          seen_keys[logic [KEY_W-1:0]];  // keys that a note may have allocated

  // Shadow copy of the table, updated in acceptance order.
  bit                shd_used [TBL_N];
  logic [KEY_W-1:0]  shd_key  [TBL_N];
  logic [TICK_W-1:0] shd_dl_last[TBL_N];
  logic [TICK_W-1:0] shd_ul_last[TBL_N];
  logic [CNT_W-1:0]  shd_dl_run [TBL_N];
  logic [CNT_W-1:0]  shd_ul_run [TBL_N];

  int unsigned accepted_items = 0;
  int unsigned bad_count      = 0;
  int unsigned idle_phase     = 0;
  bit          in_acc         = 1'b0;   // the offered item went in at the last rising edge
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;

  // Idle percentages per phase: sender then receiver; last phase runs flat out.
  int unsigned send_idle_pct[3] = '{37, 75, 0};
  int unsigned recv_idle_pct[3] = '{75, 37, 0};

  consecutive_grant_throttle_table_unit #(
    .TABLE_ENTRIES(TBL_N)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_command_i     (in_command_i),
    .in_user_key_i    (in_user_key_i),
    .in_tick_now_i    (in_tick_now_i),
    .in_grant_limit_i (in_grant_limit_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_throttle_o   (out_throttle_o),
    .out_status_o     (out_status_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Run length after a grant: extends only when the last grant was one tick ago
  // (mod 2^32), and sticks at the counter's top value.
  function automatic logic [CNT_W-1:0] next_run(logic [TICK_W-1:0] last,
                                                logic [CNT_W-1:0] run,
                                                logic [TICK_W-1:0] now);
    if (last == now - 32'd1) return (run == RUN_MAX) ? run : run + 8'd1;
    return 8'd1;
  endfunction

  // Applies one accepted item to the shadow table and returns the answer.
  function automatic verdict_t grant_table_step(grant_req_t r);
    verdict_t          v;
    int                slot;
    logic [TICK_W-1:0] last;
    logic [CNT_W-1:0]  run;
    v.throttle = 1'b0;
    slot = -1;
    // Keys are unique in the table, lowest match wins anyway.
    for (int i = 0; i < TBL_N; i++) begin
      if (slot < 0 && shd_used[i] && shd_key[i] == r.key) slot = i;
    end
    if (r.cmd == CMD_QUERY_DL || r.cmd == CMD_QUERY_UL) begin
      // Queries only look; a miss never allocates.
      if (slot < 0) begin
        v.status = ST_NONE;
      end else begin
        v.status = ST_HIT;
        last = (r.cmd == CMD_QUERY_UL) ? shd_ul_last[slot] : shd_dl_last[slot];
        run  = (r.cmd == CMD_QUERY_UL) ? shd_ul_run[slot]  : shd_dl_run[slot];
        v.throttle = (r.limit != '0) && (last == r.tick - 32'd1) && (run >= r.limit);
      end
    end else begin
      v.status = ST_HIT;
      if (slot < 0) begin
        for (int i = 0; i < TBL_N; i++) begin
          if (slot < 0 && !shd_used[i]) slot = i;
        end
        if (slot >= 0) begin
          // Fresh entry: no grant seen yet in either direction.
          shd_used[slot]    = 1'b1;
          shd_key[slot]     = r.key;
          shd_dl_last[slot] = TICK_NONE;
          shd_ul_last[slot] = TICK_NONE;
          shd_dl_run[slot]  = '0;
          shd_ul_run[slot]  = '0;
          v.status = ST_NEW;
        end else begin
          v.status = ST_NONE;  // table full, grant dropped
        end
      end
      if (slot >= 0) begin
        if (r.cmd == CMD_NOTE_UL) begin
          shd_ul_run[slot]  = next_run(shd_ul_last[slot], shd_ul_run[slot], r.tick);
          shd_ul_last[slot] = r.tick;
        end else begin
          shd_dl_run[slot]  = next_run(shd_dl_last[slot], shd_dl_run[slot], r.tick);
          shd_dl_last[slot] = r.tick;
        end
      end
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_req(cmd_e cmd, logic [KEY_W-1:0] key, logic [TICK_W-1:0] tick,
                         logic [CNT_W-1:0] limit);
    grant_req_t r;
    r.cmd   = cmd;
    r.key   = key;
    r.tick  = tick;
    r.limit = limit;
    pend_q.push_back(r);
    // Track allocations so the fill phase knows when the table is full.
    if ((cmd == CMD_NOTE_DL || cmd == CMD_NOTE_UL) && seen_keys.num() < TBL_N)
      seen_keys[key] = 1'b1;
  endtask

  // Fully random item: any command, key, tick and limit.
  task automatic add_noise();
    add_req(cmd_e'($urandom_range(3)), KEY_W'($urandom), $urandom, CNT_W'($urandom));
  endtask

  // Scheduler-like run for one user in one direction: at each tick it may ask
  // whether to skip the user, then usually grants. A skipped grant or a tick
  // gap breaks the run.
  task automatic add_burst(logic [KEY_W-1:0] key);
    cmd_e              note_c;
    cmd_e              ask_c;
    logic [TICK_W-1:0] t;
    int unsigned       n;
    note_c = $urandom_range(1) ? CMD_NOTE_UL : CMD_NOTE_DL;
    ask_c  = (note_c == CMD_NOTE_UL) ? CMD_QUERY_UL : CMD_QUERY_DL;
    case ($urandom_range(3))
      0:       t = $urandom_range(15);
      1:       t = 32'hFFFF_FFFF - $urandom_range(6);   // straddle the wrap
      default: t = $urandom;
    endcase
    n = $urandom_range(1, 12);
    repeat (n) begin
      if ($urandom_range(2) != 0) add_req(ask_c, key, t, CNT_W'($urandom_range(0, n + 1)));
      if ($urandom_range(7) != 0) add_req(note_c, key, t, CNT_W'($urandom));
      t = t + (($urandom_range(9) == 0) ? 32'd2 : 32'd1);
    end
  endtask

  task automatic add_mix(int unsigned upto, logic [KEY_W-1:0] pool[POOL_N]);
    while (pend_q.size() < upto) begin
      if ($urandom_range(4) == 0) add_noise();
      else add_burst(pool[$urandom_range(POOL_N - 1)]);
    end
  endtask

  initial begin
    logic [KEY_W-1:0]  pool[POOL_N];
    logic [KEY_W-1:0]  k16;
    logic [TICK_W-1:0] t;

    // Directed: empty-table misses, the zero-tick grant right after allocation,
    // tick wrap, limit zero, limit above the run, and a broken run.
    add_req(CMD_QUERY_DL, 16'h0000, 32'h0000_0000, 8'h00);
    add_req(CMD_QUERY_UL, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    add_req(CMD_NOTE_DL,  16'h0000, 32'h0000_0000, 8'hFF);
    add_req(CMD_QUERY_DL, 16'h0000, 32'h0000_0001, 8'h01);
    add_req(CMD_QUERY_DL, 16'h0000, 32'h0000_0001, 8'h00);
    add_req(CMD_QUERY_DL, 16'h0000, 32'h0000_0001, 8'h02);
    add_req(CMD_QUERY_UL, 16'h0000, 32'h0000_0000, 8'h01);
    add_req(CMD_NOTE_UL,  16'h0000, 32'hFFFF_FFFF, 8'h00);
    add_req(CMD_NOTE_UL,  16'h0000, 32'h0000_0000, 8'h00);
    add_req(CMD_QUERY_UL, 16'h0000, 32'h0000_0001, 8'h02);
    add_req(CMD_QUERY_UL, 16'h0000, 32'h0000_0002, 8'h01);
    add_req(CMD_NOTE_DL,  16'h0000, 32'h0000_0005, 8'h00);
    add_req(CMD_NOTE_DL,  16'hFFFF, 32'h0000_0000, 8'h00);
    add_req(CMD_NOTE_UL,  16'hFFFF, 32'h8000_0000, 8'hFF);
    add_req(CMD_QUERY_UL, 16'hFFFF, 32'h8000_0001, 8'h01);
    add_req(CMD_QUERY_DL, 16'hFFFF, 32'h0000_0001, 8'hFF);
    add_req(CMD_NOTE_DL,  16'h0000, 32'h0000_0006, 8'h00);
    add_req(CMD_QUERY_DL, 16'h0000, 32'h0000_0007, 8'h02);

    foreach (pool[i]) pool[i] = KEY_W'($urandom);
    add_mix(350, pool);

    // One long consecutive run so the counter saturates; probe near the top.
    t = $urandom;
    for (int k = 0; k < 262; k++) begin
      if (k >= 250 || k % 32 == 31)
        add_req(CMD_QUERY_DL, pool[0], t, (k % 2 == 0) ? RUN_MAX : RUN_MAX - 8'd1);
      add_req(CMD_NOTE_DL, pool[0], t, CNT_W'($urandom));
      t = t + 32'd1;
    end
    add_req(CMD_QUERY_DL, pool[0], t, RUN_MAX);

    add_mix(800, pool);

    // Fill every free entry with fresh keys.
    while (seen_keys.num() < TBL_N) begin
      k16 = KEY_W'($urandom);
      if (!seen_keys.exists(k16))
        add_req($urandom_range(1) ? CMD_NOTE_UL : CMD_NOTE_DL, k16, $urandom, CNT_W'($urandom));
    end

    // Full table: fresh keys get dropped, known keys keep working.
    add_mix(N_ITEMS, pool);
  end

  // ---------------------------------------------------------------------------
  // Reset, driver and receiver (all drive on the falling edge)
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Input driver: holds a stalled item, otherwise may idle, otherwise offers the
  // next pending one. Valid is never lowered just because of stall.
  always @(negedge clk_i) begin
    grant_req_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_acc) begin
        // still waiting for the block to take it
      end else if (pend_q.size() == 0 || $urandom_range(99) < send_idle_pct[idle_phase]) begin
        in_valid_i <= 1'b0;
      end else begin
        nxt = pend_q.pop_front();
        in_valid_i       <= 1'b1;
        in_command_i     <= nxt.cmd;
        in_user_key_i    <= nxt.key;
        in_tick_now_i    <= nxt.tick;
        in_grant_limit_i <= nxt.limit;
      end
    end
  end

  // Result receiver: random stalls per phase, and one long hold-off when the
  // flat-out phase starts so the chain backs up into the input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (idle_phase == 2 && !hold_done) begin
        hold_done   <= 1'b1;
        hold_left   <= HOLD_CYC;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct[idle_phase]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both handshakes on the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    grant_req_t taken;
    verdict_t   want;
    if (rst_ni) begin
      in_acc <= in_valid_i && !in_stall_o;

      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          bad_count++;
          $error("result item with nothing expected");
        end else begin
          want = verdict_q.pop_front();
          if (out_throttle_o !== want.throttle) begin
            bad_count++;
            $error("throttle: expected %0d, got %0d", want.throttle, out_throttle_o);
          end
          if (out_status_o !== want.status) begin
            bad_count++;
            $error("status: expected %0d, got %0d", want.status, out_status_o);
          end
        end
      end

      if (in_valid_i && !in_stall_o) begin
        taken.cmd   = cmd_e'(in_command_i);
        taken.key   = in_user_key_i;
        taken.tick  = in_tick_now_i;
        taken.limit = in_grant_limit_i;
        verdict_q.push_back(grant_table_step(taken));
        accepted_items++;
        // Idle pattern follows progress: sender-light, receiver-light, none.
        idle_phase = (accepted_items < 450) ? 0 : (accepted_items < 900) ? 1 : 2;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // End of run and watchdog
  // ---------------------------------------------------------------------------

  initial begin
    wait (rst_ni);
    while (pend_q.size() != 0 || in_valid_i || verdict_q.size() != 0) @(negedge clk_i);
    // Anything still in the chain would show up within one pass of the cells.
    repeat (TBL_N + 32) @(negedge clk_i);
    if (verdict_q.size() != 0) begin
      bad_count++;
      $error("%0d expected result items never arrived", verdict_q.size());
    end
    if (bad_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYC_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
